FILE: rtl/tfce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow cache package
// Shared types and constants of the TCP flow cache exporter.
// ----------------------------------------------------------------------------
package tfce_pkg;

  localparam int unsigned TimeoutW   = 22;
  localparam logic [21:0] TimeoutRst = 22'd60;
  localparam logic [9:0]  MsPerS     = 10'd1000;
  localparam logic [15:0] EthHdrLen  = 16'd14;
  localparam logic [15:0] EtypeIpv4  = 16'h0800;
  localparam logic [7:0]  ProtoTcp   = 8'd6;

  // Configuration register indexes.
  localparam logic [0:0] RegActive   = 1'b0;
  localparam logic [0:0] RegInactive = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] timestamp_ms;
    logic [15:0] eth_type;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] frame_length;
  } pkt_t;

  typedef struct packed {
    logic [31:0] rec_source_address;
    logic [31:0] rec_dest_address;
    logic [15:0] rec_source_port;
    logic [15:0] rec_dest_port;
    logic [31:0] rec_packets;
    logic [31:0] rec_bytes;
    logic [31:0] rec_first_ms;
    logic [31:0] rec_last_ms;
    logic [4:0]  record_slot;
    logic        datagram_end;
    logic [31:0] datagram_sequence;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic [0:0]  index;
    logic [31:0] data;
  } cfg_t;

  // One flow table entry.
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] ports;
    logic [31:0] packets;
    logic [31:0] bytes;
    logic [31:0] first_ms;
    logic [31:0] last_ms;
  } flow_t;

endpackage

FILE: rtl/tfce_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface tfce_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/tfce_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module tfce_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/tcp_flow_cache_exporter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP flow cache exporter
// Flow table with active/inactive timeouts and datagram-numbered export.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat
// pkt       in   one packet header or flush command
// rec       out  one exported flow record
// cfg       in   one timeout register write
//
// A TCP packet or a flush keeps the block busy after its accepting beat: each
// slot is read and then checked, then the matching entry is fetched, the table
// is written and the item closes. While a record cannot enter the full output
// register, the scan or the close waits. Other packets are taken and ignored.
// Reset clears valid bits, the datagram counters and sets both timeouts to 60 s.
// The newest record waits in a hold register until the scan shows it is last.
// ----------------------------------------------------------------------------
module tcp_flow_cache_exporter_unit #(
  parameter int unsigned FlowSlots          = 32,
  parameter int unsigned RecordsPerDatagram = 30
) (
  input logic clk_i,
  input logic rst_ni,
  tfce_if.sink   pkt_i,
  tfce_if.source rec_o,
  tfce_if.sink   cfg_i
);
  localparam int unsigned SlotW = (FlowSlots > 1) ? $clog2(FlowSlots) : 1;
  localparam int unsigned CntW  = $clog2(FlowSlots + 1);
  localparam logic [4:0]  RecLast = 5'(RecordsPerDatagram - 1);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRead  = 3'd1;
  localparam logic [2:0] StCheck = 3'd2;
  localparam logic [2:0] StEmit  = 3'd3;
  localparam logic [2:0] StFetch = 3'd4;
  localparam logic [2:0] StWrite = 3'd5;
  localparam logic [2:0] StClose = 3'd6;

  logic [2:0] state_q, state_d;
  logic [tfce_pkg::TimeoutW-1:0] act_s_q, ina_s_q;
  logic [31:0] act_ms_q, ina_ms_q;
  logic [FlowSlots-1:0] valid_q;
  tfce_pkg::pkt_t pkt_q;
  logic [CntW-1:0] slot_q;
  logic [4:0]  rid_q;
  logic [31:0] seq_q;
  logic        match_found_q, free_found_q;
  logic [SlotW-1:0] match_q, free_q;
  logic        lastv_found_q;
  logic [SlotW-1:0] lastv_q, lastv_d;
  tfce_pkg::rec_t rec_q, hold_q, new_rec, rec_next;
  logic        rec_valid_q, rec_valid_d;
  logic        hold_valid_q, hold_valid_d;
  logic        rec_load, release_last;

  // Flow RAM.
  logic        ram_we;
  logic [SlotW-1:0] ram_waddr, ram_raddr;
  tfce_pkg::flow_t ram_wdata, ram_rdata;

  tfce_ram #(.Width($bits(tfce_pkg::flow_t)), .Depth(FlowSlots)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The scan reads the current slot; the fetch cycle reads the matched entry.
  logic [SlotW-1:0] cur;
  assign cur = slot_q[SlotW-1:0];
  assign ram_raddr = (state_q == StFetch) ? match_q : cur;

  logic is_tcp;
  assign is_tcp = (pkt_i.data.eth_type == tfce_pkg::EtypeIpv4) &&
                  (pkt_i.data.ip_protocol == tfce_pkg::ProtoTcp);

  logic [31:0] ports_in;
  assign ports_in = {pkt_q.source_port, pkt_q.dest_port};

  logic [15:0] add_bytes;
  assign add_bytes = (pkt_q.frame_length > tfce_pkg::EthHdrLen) ?
                     pkt_q.frame_length - tfce_pkg::EthHdrLen : 16'd0;

  // Expiry check of the slot just read.
  logic expire, hit, cur_valid, out_free;
  assign cur_valid = valid_q[cur];
  assign expire = pkt_q.mode ? cur_valid :
                  cur_valid && (((pkt_q.timestamp_ms - ram_rdata.last_ms) >= ina_ms_q) ||
                                ((pkt_q.timestamp_ms - ram_rdata.first_ms) >= act_ms_q));
  assign hit = cur_valid && !expire && (ram_rdata.src == pkt_q.source_address) &&
               (ram_rdata.dst == pkt_q.dest_address) && (ram_rdata.ports == ports_in);
  assign out_free = !rec_valid_q || rec_o.ready;

  logic last_slot;
  assign last_slot = (slot_q == CntW'(FlowSlots - 1));

  // Highest valid slot, sampled when a beat is taken, marks the flush end.
  always_comb begin
    lastv_d = '0;
    for (int i = 0; i < FlowSlots; i++) begin
      if (valid_q[i]) lastv_d = SlotW'(i);
    end
  end

  logic flush_end;
  assign flush_end = pkt_q.mode && lastv_found_q && (lastv_q == cur);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (pkt_i.valid && (pkt_i.data.mode || is_tcp)) state_d = StRead;
      StRead:  state_d = StCheck;
      StCheck: begin
        if (expire) state_d = out_free ? (last_slot ? StFetch : StRead) : StEmit;
        else state_d = last_slot ? StFetch : StRead;
      end
      StEmit:  if (out_free) state_d = last_slot ? StFetch : StRead;
      StFetch: state_d = StWrite;
      StWrite: state_d = StClose;
      StClose: if (out_free || !hold_valid_q) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  logic do_emit;
  assign do_emit = ((state_q == StCheck) && expire && out_free) ||
                   ((state_q == StEmit) && out_free);

  // Table write at end of a packet.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = match_q;
    ram_wdata = ram_rdata;
    if (state_q == StWrite && !pkt_q.mode) begin
      if (match_found_q) begin
        ram_we    = 1'b1;
        ram_waddr = match_q;
        ram_wdata.packets = ram_rdata.packets + 32'd1;
        ram_wdata.bytes   = ram_rdata.bytes + 32'(add_bytes);
        ram_wdata.last_ms = pkt_q.timestamp_ms;
      end else if (free_found_q) begin
        ram_we    = 1'b1;
        ram_waddr = free_q;
        ram_wdata = '{src: pkt_q.source_address, dst: pkt_q.dest_address,
                      ports: ports_in, packets: 32'd1, bytes: 32'(add_bytes),
                      first_ms: pkt_q.timestamp_ms, last_ms: pkt_q.timestamp_ms};
      end
    end
  end

  // Record built from the slot being exported.
  always_comb begin
    new_rec.rec_source_address = ram_rdata.src;
    new_rec.rec_dest_address   = ram_rdata.dst;
    new_rec.rec_source_port    = ram_rdata.ports[31:16];
    new_rec.rec_dest_port      = ram_rdata.ports[15:0];
    new_rec.rec_packets        = ram_rdata.packets;
    new_rec.rec_bytes          = ram_rdata.bytes;
    new_rec.rec_first_ms       = ram_rdata.first_ms;
    new_rec.rec_last_ms        = ram_rdata.last_ms;
    new_rec.record_slot        = rid_q;
    new_rec.datagram_end       = (rid_q == RecLast) || flush_end;
    new_rec.datagram_sequence  = seq_q;
    new_rec.last               = 1'b0;
  end

  // A held record moves out when the next one arrives, or with its last
  // flag set when the item closes.
  assign release_last = (state_q == StClose) && out_free && hold_valid_q;
  assign rec_load     = (do_emit && hold_valid_q) || release_last;
  assign rec_valid_d  = rec_load || (rec_valid_q && !rec_o.ready);
  assign hold_valid_d = do_emit || (hold_valid_q && !release_last);

  always_comb begin
    rec_next      = hold_q;
    rec_next.last = release_last;
  end

  logic [31:0] ms_prod;
  logic        cfg_phase_q;
  assign ms_prod = 32'(cfg_phase_q ? ina_s_q : act_s_q) * 32'(tfce_pkg::MsPerS);

  assign pkt_i.ready = (state_q == StIdle);
  assign cfg_i.ready = 1'b1;
  assign rec_o.valid = rec_valid_q;
  assign rec_o.data  = rec_q;

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && pkt_i.valid) pkt_q <= pkt_i.data;
    if (do_emit) hold_q <= new_rec;
    if (rec_load) rec_q <= rec_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      act_s_q       <= tfce_pkg::TimeoutRst;
      ina_s_q       <= tfce_pkg::TimeoutRst;
      act_ms_q      <= 32'd60000;
      ina_ms_q      <= 32'd60000;
      cfg_phase_q   <= 1'b0;
      valid_q       <= '0;
      slot_q        <= '0;
      rid_q         <= '0;
      seq_q         <= '0;
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      match_q       <= '0;
      free_q        <= '0;
      lastv_found_q <= 1'b0;
      lastv_q       <= '0;
      rec_valid_q   <= 1'b0;
      hold_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rec_valid_q  <= rec_valid_d;
      hold_valid_q <= hold_valid_d;
      // Timeout registers and their millisecond products, one per cycle.
      if (cfg_i.valid) begin
        if (cfg_i.data.index == tfce_pkg::RegActive) begin
          act_s_q <= cfg_i.data.data[tfce_pkg::TimeoutW-1:0];
        end else begin
          ina_s_q <= cfg_i.data.data[tfce_pkg::TimeoutW-1:0];
        end
      end
      cfg_phase_q <= !cfg_phase_q;
      if (cfg_phase_q) ina_ms_q <= ms_prod;
      else act_ms_q <= ms_prod;

      unique case (state_q)
        StIdle: begin
          slot_q        <= '0;
          match_found_q <= 1'b0;
          free_found_q  <= 1'b0;
          lastv_found_q <= |valid_q;
          lastv_q       <= lastv_d;
        end
        StCheck, StEmit: begin
          if (state_q == StCheck) begin
            if (hit && !match_found_q) begin
              match_found_q <= 1'b1;
              match_q       <= cur;
            end
            if ((!cur_valid || expire) && !free_found_q) begin
              free_found_q <= 1'b1;
              free_q       <= cur;
            end
          end
          if (do_emit) begin
            valid_q[cur] <= 1'b0;
            if (rid_q == RecLast) begin
              rid_q <= '0;
              seq_q <= seq_q + 32'(RecordsPerDatagram);
            end else begin
              rid_q <= rid_q + 5'd1;
            end
          end
          if (state_d != state_q || state_q == StCheck) begin
            if (state_d == StRead) slot_q <= slot_q + CntW'(1);
          end
        end
        StWrite: begin
          if (!pkt_q.mode && !match_found_q && free_found_q) valid_q[free_q] <= 1'b1;
          if (pkt_q.mode) begin
            seq_q <= seq_q + 32'(rid_q);
            rid_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Protocol and counter checks.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !pkt_i.ready)
    else $error("packet accepted while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rec_o.valid && !rec_o.ready) |=> (rec_o.valid && $stable(rec_o.data)))
    else $error("record changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rid_q <= RecLast)
    else $error("datagram position out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !hold_valid_q)
    else $error("record left in hold register");
endmodule

FILE: bench/tfce_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow cache checker
// Watches the packet, record and register channels of the flow cache,
// predicts every exported record and compares it field by field.
// ----------------------------------------------------------------------------
module tfce_checker #(
  parameter int unsigned FlowSlots          = 32,
  parameter int unsigned RecordsPerDatagram = 30
) (
  input  logic clk_i,
  input  logic rst_ni,
  tfce_if      pkt_mon,
  tfce_if      rec_mon,
  tfce_if      cfg_mon,
  output int   pending_o,
  output int   errors_o
);

  // Shadow copy of the flow table and the export counters.
  logic [tfce_pkg::TimeoutW-1:0] active_s;
  logic [tfce_pkg::TimeoutW-1:0] inactive_s;
  logic            flow_live [FlowSlots];
  tfce_pkg::flow_t flows     [FlowSlots];
  logic [31:0]     dgram_fill;
  logic [31:0]     export_seq;
  tfce_pkg::rec_t  expected_records[$];
  int              errors;

  assign pending_o = expected_records.size();
  assign errors_o  = errors;

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // Turn one live slot into a record and advance the datagram position.
  task automatic export_flow(int s, bit force_end);
    tfce_pkg::rec_t r;
    bit   full;
    full = (dgram_fill + 1) >= RecordsPerDatagram;
    r.rec_source_address = flows[s].src;
    r.rec_dest_address   = flows[s].dst;
    r.rec_source_port    = flows[s].ports[31:16];
    r.rec_dest_port      = flows[s].ports[15:0];
    r.rec_packets        = flows[s].packets;
    r.rec_bytes          = flows[s].bytes;
    r.rec_first_ms       = flows[s].first_ms;
    r.rec_last_ms        = flows[s].last_ms;
    r.record_slot        = dgram_fill[4:0];
    r.datagram_end       = full || force_end;
    r.datagram_sequence  = export_seq;
    r.last               = 1'b0;
    flow_live[s] = 1'b0;
    expected_records.push_back(r);
    if (full) begin
      export_seq += RecordsPerDatagram;
      dgram_fill = 0;
    end else begin
      dgram_fill++;
    end
  endtask

  // Work out the records caused by one packet or flush beat.
  task automatic predict_records(tfce_pkg::pkt_t p);
    int          base;
    int          last_live;
    int          hit;
    int          free_s;
    logic [31:0] ports;
    logic [31:0] add;
    logic [31:0] ina;
    logic [31:0] act;
    base = expected_records.size();
    if (p.mode) begin
      last_live = -1;
      for (int s = 0; s < FlowSlots; s++) if (flow_live[s]) last_live = s;
      for (int s = 0; s < FlowSlots; s++) if (flow_live[s]) export_flow(s, s == last_live);
      export_seq += dgram_fill;
      dgram_fill = 0;
    end else if (p.eth_type == tfce_pkg::EtypeIpv4 && p.ip_protocol == tfce_pkg::ProtoTcp) begin
      ports = {p.source_port, p.dest_port};
      add   = (p.frame_length > tfce_pkg::EthHdrLen) ?
              32'(p.frame_length - tfce_pkg::EthHdrLen) : 32'd0;
      ina   = 32'(inactive_s) * 32'(tfce_pkg::MsPerS);
      act   = 32'(active_s) * 32'(tfce_pkg::MsPerS);
      hit   = -1;
      free_s = -1;
      // Expiry pass in slot order.
      for (int s = 0; s < FlowSlots; s++) begin
        if (flow_live[s] && ((p.timestamp_ms - flows[s].last_ms) >= ina ||
                             (p.timestamp_ms - flows[s].first_ms) >= act))
          export_flow(s, 1'b0);
      end
      for (int s = 0; s < FlowSlots; s++) begin
        if (flow_live[s]) begin
          if (hit < 0 && flows[s].src == p.source_address &&
              flows[s].dst == p.dest_address && flows[s].ports == ports)
            hit = s;
        end else if (free_s < 0) begin
          free_s = s;
        end
      end
      if (hit >= 0) begin
        flows[hit].packets += 1;
        flows[hit].bytes   += add;
        flows[hit].last_ms  = p.timestamp_ms;
      end else if (free_s >= 0) begin
        flow_live[free_s]      = 1'b1;
        flows[free_s].src      = p.source_address;
        flows[free_s].dst      = p.dest_address;
        flows[free_s].ports    = ports;
        flows[free_s].packets  = 32'd1;
        flows[free_s].bytes    = add;
        flows[free_s].first_ms = p.timestamp_ms;
        flows[free_s].last_ms  = p.timestamp_ms;
      end
    end
    if (expected_records.size() > base)
      expected_records[expected_records.size() - 1].last = 1'b1;
  endtask

  // Compare an observed record with the oldest expectation.
  task automatic check_record(tfce_pkg::rec_t got);
    tfce_pkg::rec_t w;
    if (expected_records.size() == 0) begin
      report("unexpected record", 32'd1, 32'd0);
      return;
    end
    w = expected_records.pop_front();
    if (got.rec_source_address !== w.rec_source_address)
      report("rec_source_address", got.rec_source_address, w.rec_source_address);
    if (got.rec_dest_address !== w.rec_dest_address)
      report("rec_dest_address", got.rec_dest_address, w.rec_dest_address);
    if (got.rec_source_port !== w.rec_source_port)
      report("rec_source_port", 32'(got.rec_source_port), 32'(w.rec_source_port));
    if (got.rec_dest_port !== w.rec_dest_port)
      report("rec_dest_port", 32'(got.rec_dest_port), 32'(w.rec_dest_port));
    if (got.rec_packets !== w.rec_packets)
      report("rec_packets", got.rec_packets, w.rec_packets);
    if (got.rec_bytes !== w.rec_bytes) report("rec_bytes", got.rec_bytes, w.rec_bytes);
    if (got.rec_first_ms !== w.rec_first_ms)
      report("rec_first_ms", got.rec_first_ms, w.rec_first_ms);
    if (got.rec_last_ms !== w.rec_last_ms)
      report("rec_last_ms", got.rec_last_ms, w.rec_last_ms);
    if (got.record_slot !== w.record_slot)
      report("record_slot", 32'(got.record_slot), 32'(w.record_slot));
    if (got.datagram_end !== w.datagram_end)
      report("datagram_end", 32'(got.datagram_end), 32'(w.datagram_end));
    if (got.datagram_sequence !== w.datagram_sequence)
      report("datagram_sequence", got.datagram_sequence, w.datagram_sequence);
    if (got.last !== w.last) report("last", 32'(got.last), 32'(w.last));
  endtask

  // Records are checked before the packet of the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_s   = tfce_pkg::TimeoutRst;
      inactive_s = tfce_pkg::TimeoutRst;
      dgram_fill = '0;
      export_seq = '0;
      errors     = 0;
      for (int s = 0; s < FlowSlots; s++) flow_live[s] = 1'b0;
      expected_records.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.data.index == tfce_pkg::RegActive) begin
          active_s = cfg_mon.data.data[tfce_pkg::TimeoutW-1:0];
        end else begin
          inactive_s = cfg_mon.data.data[tfce_pkg::TimeoutW-1:0];
        end
      end
      if (rec_mon.valid && rec_mon.ready) check_record(rec_mon.data);
      if (pkt_mon.valid && pkt_mon.ready) predict_records(pkt_mon.data);
    end
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow cache testbench
// Drives packets, flushes and timeout writes into the flow cache, with random
// gaps and record back-pressure; a checker beside the block scores records.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 80;

  logic clk_i;
  logic rst_ni;
  int   pending;
  int   errors;
  int   cycle = 0;
  int   quiet = 0;
  bit   no_gaps;
  logic [31:0] now_ms;
  logic [31:0] key_src [16];
  logic [31:0] key_dst [16];
  logic [15:0] key_sp  [16];
  logic [15:0] key_dp  [16];

  tfce_if #(.T(tfce_pkg::pkt_t)) pkt_ch ();
  tfce_if #(.T(tfce_pkg::rec_t)) rec_ch ();
  tfce_if #(.T(tfce_pkg::cfg_t)) cfg_ch ();

  tcp_flow_cache_exporter_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pkt_i  (pkt_ch),
    .rec_o  (rec_ch),
    .cfg_i  (cfg_ch)
  );

  tfce_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pkt_mon   (pkt_ch),
    .rec_mon   (rec_ch),
    .cfg_mon   (cfg_ch),
    .pending_o (pending),
    .errors_o  (errors)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Record back-pressure, with a long window of full throughput.
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > 3000 && cycle < 7000) rec_ch.ready <= 1'b1;
    else rec_ch.ready <= ($urandom_range(0, 99) >= 9);
  end

  // Watchdog on cycles with no beat on any channel.
  always @(posedge clk_i) begin
    if ((pkt_ch.valid && pkt_ch.ready) || (rec_ch.valid && rec_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= WatchdogLimit) begin
      $display("tcp_flow_cache_exporter_unit test failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_beat(tfce_pkg::pkt_t p);
    while (!no_gaps && $urandom_range(0, 99) < 9) begin
      pkt_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    pkt_ch.valid <= 1'b1;
    pkt_ch.data  <= p;
    do @(posedge clk_i); while (!pkt_ch.ready);
  endtask

  // Drop valid and wait until every expected record has come out.
  task automatic drain;
    pkt_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{index: idx, data: val};
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic tfce_pkg::pkt_t tcp_beat(logic [31:0] ts, int k, logic [15:0] len);
    tfce_pkg::pkt_t p;
    p.mode = 1'b0;
    p.timestamp_ms = ts;
    p.eth_type = tfce_pkg::EtypeIpv4;
    p.ip_protocol = tfce_pkg::ProtoTcp;
    p.source_address = key_src[k];
    p.dest_address = key_dst[k];
    p.source_port = key_sp[k];
    p.dest_port = key_dp[k];
    p.frame_length = len;
    return p;
  endfunction

  // Fully random header bits.
  function automatic tfce_pkg::pkt_t rand_beat();
    logic [191:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return bits[$bits(tfce_pkg::pkt_t)-1:0];
  endfunction

  function automatic tfce_pkg::pkt_t flush_beat();
    tfce_pkg::pkt_t p;
    p = rand_beat();
    p.mode = 1'b1;
    return p;
  endfunction

  task automatic new_keys;
    for (int k = 0; k < 16; k++) begin
      key_src[k] = $urandom;
      key_dst[k] = $urandom;
      key_sp[k]  = 16'($urandom);
      key_dp[k]  = 16'($urandom);
    end
  endtask

  // Mostly pool-keyed TCP packets, some flushes and some ignored noise.
  task automatic random_traffic(int count, int max_step, int keys);
    tfce_pkg::pkt_t p;
    int   roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      now_ms += $urandom_range(0, max_step);
      if (roll < 5) begin
        p = flush_beat();
      end else if (roll < 15) begin
        p = rand_beat();
        p.mode = 1'b0;
        if ($urandom_range(0, 1)) p.eth_type = tfce_pkg::EtypeIpv4;
        else p.ip_protocol = tfce_pkg::ProtoTcp;
        if (p.eth_type == tfce_pkg::EtypeIpv4 && p.ip_protocol == tfce_pkg::ProtoTcp)
          p.ip_protocol = 8'd17;
      end else begin
        p = tcp_beat(now_ms, $urandom_range(0, keys - 1),
                     ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1514)));
      end
      send_beat(p);
      if (i == count / 2) drain();
    end
  endtask

  initial begin
    tfce_pkg::pkt_t p;
    rst_ni       = 1'b0;
    no_gaps      = 1'b0;
    now_ms       = 32'hFFFF_0000;
    pkt_ch.valid = 1'b0;
    pkt_ch.data  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    new_keys();
    key_src[0] = 32'h0;  key_dst[0] = 32'hFFFF_FFFF; key_sp[0] = 16'h0; key_dp[0] = 16'hFFFF;
    key_src[1] = 32'hFFFF_FFFF; key_dst[1] = 32'h0;  key_sp[1] = 16'hFFFF; key_dp[1] = 16'h0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset timeouts, byte floor, ignored frames, wrap and flushes.
    send_beat(tcp_beat(now_ms, 0, 16'd0));
    send_beat(tcp_beat(now_ms + 1, 0, 16'd14));
    send_beat(tcp_beat(now_ms + 2, 0, 16'd15));
    send_beat(tcp_beat(now_ms + 3, 1, 16'hFFFF));
    p = tcp_beat(now_ms + 4, 2, 16'd100);
    p.eth_type = 16'h86DD;
    send_beat(p);
    p.eth_type = tfce_pkg::EtypeIpv4;
    p.ip_protocol = 8'd17;
    send_beat(p);
    p.eth_type = 16'hFFFF;
    p.ip_protocol = 8'hFF;
    send_beat(p);
    send_beat(tcp_beat(now_ms + 5, 2, 16'd60));
    now_ms += 32'd70_000;  // crosses the 32-bit wrap; inactive expiry of all
    send_beat(tcp_beat(now_ms, 3, 16'd1514));
    send_beat(tcp_beat(now_ms + 10, 3, 16'd64));
    send_beat(flush_beat());
    send_beat(flush_beat());
    drain();

    // One-second timeouts: frequent expiry.
    write_reg(tfce_pkg::RegActive, 32'hFFC0_0001);
    write_reg(tfce_pkg::RegInactive, 32'd1);
    new_keys();
    random_traffic(90, 1500, 10);
    drain();

    // Longest timeouts, no gaps: fill the table past full, then flush.
    write_reg(tfce_pkg::RegActive, 32'h003F_FFFF);
    write_reg(tfce_pkg::RegInactive, 32'hFFFF_FFFF);
    no_gaps = 1'b1;
    for (int i = 0; i < 45; i++) begin
      if (i % 16 == 0) new_keys();
      now_ms += 32'd7;
      send_beat(tcp_beat(now_ms, i % 16, 16'($urandom)));
    end
    send_beat(flush_beat());
    no_gaps = 1'b0;
    drain();

    // Mid timeouts with a larger key pool.
    write_reg(tfce_pkg::RegActive, 32'($urandom_range(2, 5)));
    write_reg(tfce_pkg::RegInactive, 32'($urandom_range(1, 3)));
    new_keys();
    random_traffic(130, 900, 16);
    send_beat(flush_beat());
    drain();

    if (errors == 0) begin
      $display("tcp_flow_cache_exporter_unit test passed");
    end else begin
      $display("tcp_flow_cache_exporter_unit test failed");
    end
    $finish;
  end

endmodule
